// ----- rtl/sac_pkg.sv -----
// shared constants, types and config register indexes for the lfu cache tag store
// no dependencies
package sac_pkg;

	localparam int WAYS        = 4;
	localparam int SETS        = 256;
	localparam int COUNT_W     = 16;
	localparam int ADDR_W      = 64;
	localparam int TAG_W       = 64;
	localparam int SET_W       = 8;
	localparam int WAY_W       = 2;
	localparam int SB_W        = 4;
	localparam int OB_W        = 4;
	localparam int WAYS_CFG_W  = 3;
	localparam int SHIFT_W     = 5;
	localparam int MAX_SET_BITS = 8;
	localparam int TOTAL_W     = 32;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 4;

	localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 2'd2;

	localparam logic [SB_W-1:0]       SET_BITS_RST = 4'd8;
	localparam logic [OB_W-1:0]       OFFSET_BITS_RST = 4'd6;
	localparam logic [WAYS_CFG_W-1:0] WAYS_RST = 3'd4;

	typedef enum logic [1:0] {
		OUT_HIT   = 2'd0,
		OUT_FILL  = 2'd1,
		OUT_EVICT = 2'd2
	} outcome_t;

	typedef struct packed {
		logic [WAYS-1:0]              valid;
		logic [WAYS-1:0][TAG_W-1:0]   tag;
		logic [WAYS-1:0][COUNT_W-1:0] count;
	} row_t;

	localparam int ROW_W = $bits(row_t);

	typedef struct packed {
		outcome_t         outcome;
		logic [WAY_W-1:0] way;
	} decision_t;

endpackage

// ----- rtl/sac_if.sv -----
// request and response channel interfaces of the lfu cache tag store
// depends on sac_pkg
interface sac_req_if;
	import sac_pkg::*;

	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] address;

	modport source (output valid, output address, input ready);
	modport sink (input valid, input address, output ready);
endinterface

interface sac_rsp_if;
	import sac_pkg::*;

	logic               valid;
	logic               ready;
	logic [1:0]         outcome;
	logic [SET_W-1:0]   set_index;
	logic [TAG_W-1:0]   line_tag;
	logic [WAY_W-1:0]   way_used;
	logic [TOTAL_W-1:0] hit_total;
	logic [TOTAL_W-1:0] miss_total;
	logic [TOTAL_W-1:0] evict_total;

	modport source (output valid, output outcome, output set_index, output line_tag,
		output way_used, output hit_total, output miss_total, output evict_total,
		input ready);
	modport sink (input valid, input outcome, input set_index, input line_tag,
		input way_used, input hit_total, input miss_total, input evict_total,
		output ready);
endinterface

// ----- rtl/sac_decode.sv -----
// address split into tag and set index, and way-in-use mask from the config registers
// depends on sac_pkg
module sac_decode (
	input  logic [sac_pkg::ADDR_W-1:0]     address,
	input  logic [sac_pkg::SB_W-1:0]       set_bits,
	input  logic [sac_pkg::OB_W-1:0]       offset_bits,
	input  logic [sac_pkg::WAYS_CFG_W-1:0] ways_in_use,
	output logic [sac_pkg::TAG_W-1:0]      tag,
	output logic [sac_pkg::SET_W-1:0]      set_index,
	output logic [sac_pkg::WAYS-1:0]       used
);
	import sac_pkg::*;

	logic [SB_W-1:0]       sb;
	logic [SHIFT_W-1:0]    shift;
	logic [SET_W-1:0]      raw_set;
	logic [SET_W-1:0]      set_mask;
	logic [WAYS_CFG_W-1:0] ways;

	always_comb begin
		sb = (set_bits > SB_W'(MAX_SET_BITS)) ? SB_W'(MAX_SET_BITS) : set_bits;
		shift = SHIFT_W'(sb) + SHIFT_W'(offset_bits);
		tag = TAG_W'(address >> shift);
		raw_set = SET_W'(address >> offset_bits);
		set_mask = SET_W'(((SET_W+1)'(1) << sb) - (SET_W+1)'(1));
		set_index = raw_set & set_mask;
		if (ways_in_use == '0) begin
			ways = WAYS_CFG_W'(1);
		end else if (ways_in_use > WAYS_CFG_W'(WAYS)) begin
			ways = WAYS_CFG_W'(WAYS);
		end else begin
			ways = ways_in_use;
		end
		for (int w = 0; w < WAYS; w++) begin
			used[w] = (WAYS_CFG_W'(w) < ways);
		end
	end

endmodule

// ----- rtl/sac_store.sv -----
// set row memory with registered read and per-set row valid flops
// depends on sac_pkg
module sac_store (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      rd_en,
	input  logic [sac_pkg::SET_W-1:0] rd_set,
	input  logic                      wr_en,
	input  logic [sac_pkg::SET_W-1:0] wr_set,
	input  sac_pkg::row_t             wr_row,
	output sac_pkg::row_t             rd_row
);
	import sac_pkg::*;

	logic [ROW_W-1:0] mem [SETS];
	logic [ROW_W-1:0] rd_data_q;
	logic [SETS-1:0]  row_valid_q;
	logic             row_valid_s1;
	row_t             raw_row;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_set] <= wr_row;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_set];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			row_valid_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				row_valid_q[wr_set] <= 1'b1;
			end
			if (rd_en) begin
				row_valid_s1 <= row_valid_q[rd_set];
			end
		end
	end

	// a never-written set reads as all lines invalid with zero counts
	always_comb begin
		raw_row = row_t'(rd_data_q);
		rd_row = raw_row;
		if (!row_valid_s1) begin
			rd_row.valid = '0;
			rd_row.count = '0;
		end
	end

endmodule

// ----- rtl/sac_way_logic.sv -----
// parallel way compare, free-line and lfu victim pick, and updated set row
// depends on sac_pkg
module sac_way_logic (
	input  sac_pkg::row_t             row,
	input  logic [sac_pkg::TAG_W-1:0] tag,
	input  logic [sac_pkg::WAYS-1:0]  used,
	output sac_pkg::decision_t        decision,
	output sac_pkg::row_t             new_row
);
	import sac_pkg::*;

	logic [WAYS-1:0]    hit_vec;
	logic [WAYS-1:0]    free_vec;
	logic [WAY_W-1:0]   hit_way;
	logic [WAY_W-1:0]   free_way;
	logic [WAY_W-1:0]   lfu_way;
	logic [COUNT_W-1:0] best;
	logic [COUNT_W-1:0] old_count;
	logic [WAY_W-1:0]   way;

	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			hit_vec[w] = used[w] & row.valid[w] & (row.tag[w] == tag);
			free_vec[w] = used[w] & ~row.valid[w];
		end

		hit_way = '0;
		free_way = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (hit_vec[w]) begin
				hit_way = WAY_W'(w);
			end
			if (free_vec[w]) begin
				free_way = WAY_W'(w);
			end
		end

		// lowest way wins a tie
		best = row.count[0];
		lfu_way = '0;
		for (int w = 1; w < WAYS; w++) begin
			if (used[w] && (row.count[w] < best)) begin
				best = row.count[w];
				lfu_way = WAY_W'(w);
			end
		end

		if (|hit_vec) begin
			decision.outcome = OUT_HIT;
			way = hit_way;
		end else if (|free_vec) begin
			decision.outcome = OUT_FILL;
			way = free_way;
		end else begin
			decision.outcome = OUT_EVICT;
			way = lfu_way;
		end
		decision.way = way;

		old_count = row.count[way];
		new_row = row;
		case (decision.outcome)
			OUT_HIT: begin
				new_row.count[way] = (&old_count) ? old_count : old_count + COUNT_W'(1);
			end
			OUT_FILL: begin
				new_row.valid[way] = 1'b1;
				new_row.tag[way] = tag;
				new_row.count[way] = (&old_count) ? old_count : old_count + COUNT_W'(1);
			end
			OUT_EVICT: begin
				new_row.tag[way] = tag;
				new_row.count[way] = '0;
			end
			default: begin
				new_row = row;
			end
		endcase
	end

endmodule

// ----- rtl/set_assoc_cache_lfu_tags.sv -----
// Tag store of a 4-way, 256-set cache with least-frequently-used replacement. Each address
// is handled in order: the set row is read from the row memory into a register, and then
// all ways are compared, the hit, free or victim line is chosen and the row is written back.
// The write-back and the next read of the row memory cannot overlap, so a new address
// is taken only after the write-back; a result waiting in the output register holds the
// item in flight until it is taken. Per-set valid flops clear with reset, so no clearing
// pass is needed. Config registers must be written only while the block is idle.
// depends on sac_pkg, sac_if, sac_decode, sac_store, sac_way_logic
module set_assoc_cache_lfu_tags (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [sac_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sac_pkg::CFG_DATA_W-1:0] cfg_data,
	sac_req_if.sink                        req,
	sac_rsp_if.source                      rsp
);
	import sac_pkg::*;

	logic [SB_W-1:0]       set_bits_q;
	logic [OB_W-1:0]       offset_bits_q;
	logic [WAYS_CFG_W-1:0] ways_in_use_q;

	logic [TAG_W-1:0]   dec_tag;
	logic [SET_W-1:0]   dec_set;
	logic [WAYS-1:0]    dec_used;

	logic               busy_s1;
	logic [TAG_W-1:0]   tag_s1;
	logic [SET_W-1:0]   set_s1;
	logic [WAYS-1:0]    used_s1;

	row_t               rd_row;
	row_t               new_row;
	decision_t          decision;

	logic [TOTAL_W-1:0] hits_q;
	logic [TOTAL_W-1:0] misses_q;
	logic [TOTAL_W-1:0] evicts_q;
	logic [TOTAL_W-1:0] hits_next;
	logic [TOTAL_W-1:0] misses_next;
	logic [TOTAL_W-1:0] evicts_next;

	logic               rsp_valid_q;
	outcome_t           outcome_q;
	logic [SET_W-1:0]   set_q;
	logic [TAG_W-1:0]   tag_q;
	logic [WAY_W-1:0]   way_q;

	logic               req_xfer;
	logic               advance;

	assign req.ready = !busy_s1;
	assign req_xfer = req.valid & !busy_s1;
	assign advance = busy_s1 & (!rsp_valid_q | rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q <= SET_BITS_RST;
			offset_bits_q <= OFFSET_BITS_RST;
			ways_in_use_q <= WAYS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SET_BITS: set_bits_q <= cfg_data[SB_W-1:0];
				CFG_OFFSET_BITS: offset_bits_q <= cfg_data[OB_W-1:0];
				CFG_WAYS_IN_USE: ways_in_use_q <= cfg_data[WAYS_CFG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	sac_decode u_decode (
		.address     (req.address),
		.set_bits    (set_bits_q),
		.offset_bits (offset_bits_q),
		.ways_in_use (ways_in_use_q),
		.tag         (dec_tag),
		.set_index   (dec_set),
		.used        (dec_used)
	);

	sac_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (req_xfer),
		.rd_set (dec_set),
		.wr_en  (advance),
		.wr_set (set_s1),
		.wr_row (new_row),
		.rd_row (rd_row)
	);

	sac_way_logic u_way_logic (
		.row      (rd_row),
		.tag      (tag_s1),
		.used     (used_s1),
		.decision (decision),
		.new_row  (new_row)
	);

	always_ff @(posedge clk) begin
		if (req_xfer) begin
			tag_s1 <= dec_tag;
			set_s1 <= dec_set;
			used_s1 <= dec_used;
		end
		if (advance) begin
			outcome_q <= decision.outcome;
			set_q <= set_s1;
			tag_q <= tag_s1;
			way_q <= decision.way;
		end
	end

	always_comb begin
		hits_next = hits_q;
		misses_next = misses_q;
		evicts_next = evicts_q;
		if (decision.outcome == OUT_HIT) begin
			hits_next = (&hits_q) ? hits_q : hits_q + TOTAL_W'(1);
		end else begin
			misses_next = (&misses_q) ? misses_q : misses_q + TOTAL_W'(1);
		end
		if (decision.outcome == OUT_EVICT) begin
			evicts_next = (&evicts_q) ? evicts_q : evicts_q + TOTAL_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
			rsp_valid_q <= 1'b0;
			hits_q <= '0;
			misses_q <= '0;
			evicts_q <= '0;
		end else begin
			if (req_xfer) begin
				busy_s1 <= 1'b1;
			end else if (advance) begin
				busy_s1 <= 1'b0;
			end
			if (advance) begin
				rsp_valid_q <= 1'b1;
				hits_q <= hits_next;
				misses_q <= misses_next;
				evicts_q <= evicts_next;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.outcome = outcome_q;
	assign rsp.set_index = set_q;
	assign rsp.line_tag = tag_q;
	assign rsp.way_used = way_q;
	assign rsp.hit_total = hits_q;
	assign rsp.miss_total = misses_q;
	assign rsp.evict_total = evicts_q;

endmodule

// ----- verif/tb_top.sv -----
// self-checking testbench for the lfu cache tag store: directed and random address streams
// are checked field by field against a behavioral model of the tag store kept in this file
// depends on sac_pkg, sac_if and set_assoc_cache_lfu_tags
module tb_top;
	import sac_pkg::*;

	localparam int STALL_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 20;
	localparam int PHASE_ITEMS = 193;

	typedef struct {
		outcome_t            outcome;
		logic [SET_W-1:0]    set_index;
		logic [TAG_W-1:0]    line_tag;
		logic [WAY_W-1:0]    way_used;
		logic [TOTAL_W-1:0]  hit_total;
		logic [TOTAL_W-1:0]  miss_total;
		logic [TOTAL_W-1:0]  evict_total;
	} lookup_result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	sac_req_if req_ch ();
	sac_rsp_if rsp_ch ();

	set_assoc_cache_lfu_tags dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	// model of the tag store
	bit                      line_ok   [SETS][WAYS];
	bit [TAG_W-1:0]          line_tags [SETS][WAYS];
	bit [COUNT_W-1:0]        use_count [SETS][WAYS];
	bit [TOTAL_W-1:0]        hit_cnt, miss_cnt, evict_cnt;
	logic [SB_W-1:0]         cur_set_bits;
	logic [OB_W-1:0]         cur_offset_bits;
	logic [WAYS_CFG_W-1:0]   cur_ways;

	lookup_result_t pending_lookups[$];
	int  mismatches;
	int  rsp_hold;
	int  idle_cycles;
	bit  quiet;
	bit  offering;
	int  rsp_stall_left;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic int eff_set_bits();
		return (cur_set_bits > MAX_SET_BITS) ? MAX_SET_BITS : int'(cur_set_bits);
	endfunction

	function automatic int eff_ways();
		if (cur_ways == 0)
			return 1;
		if (cur_ways > WAYS)
			return WAYS;
		return int'(cur_ways);
	endfunction

	function automatic lookup_result_t predict_access(logic [ADDR_W-1:0] addr);
		int sb, ob, nways, set, way, w;
		bit found, free_found;
		logic [TAG_W-1:0] tag;
		logic [COUNT_W-1:0] best;
		lookup_result_t r;
		sb = eff_set_bits();
		ob = int'(cur_offset_bits);
		nways = eff_ways();
		tag = addr >> (sb + ob);
		set = int'((addr >> ob) & ((64'd1 << sb) - 64'd1)) % SETS;
		found = 0;
		free_found = 0;
		way = 0;
		for (w = 0; w < nways && !found; w++) begin
			if (line_ok[set][w] && line_tags[set][w] == tag) begin
				way = w;
				found = 1;
			end
		end
		if (found) begin
			r.outcome = OUT_HIT;
			if (use_count[set][way] != '1)
				use_count[set][way]++;
			if (hit_cnt != '1)
				hit_cnt++;
		end else begin
			for (w = 0; w < nways && !free_found; w++) begin
				if (!line_ok[set][w]) begin
					way = w;
					free_found = 1;
				end
			end
			if (miss_cnt != '1)
				miss_cnt++;
			if (free_found) begin
				r.outcome = OUT_FILL;
				line_ok[set][way] = 1;
				line_tags[set][way] = tag;
				if (use_count[set][way] != '1)
					use_count[set][way]++;
			end else begin
				r.outcome = OUT_EVICT;
				way = 0;
				best = use_count[set][0];
				for (w = 1; w < nways; w++) begin
					if (use_count[set][w] < best) begin
						best = use_count[set][w];
						way = w;
					end
				end
				line_tags[set][way] = tag;
				use_count[set][way] = '0;
				if (evict_cnt != '1)
					evict_cnt++;
			end
		end
		r.set_index = set[SET_W-1:0];
		r.line_tag = tag;
		r.way_used = way[WAY_W-1:0];
		r.hit_total = hit_cnt;
		r.miss_total = miss_cnt;
		r.evict_total = evict_cnt;
		return r;
	endfunction

	function automatic logic [ADDR_W-1:0] make_address(logic [TAG_W-1:0] tag, int set,
			logic [ADDR_W-1:0] off);
		int sb, ob;
		sb = eff_set_bits();
		ob = int'(cur_offset_bits);
		return (tag << (sb + ob)) | ((64'(set) & ((64'd1 << sb) - 64'd1)) << ob)
			| (off & ((64'd1 << ob) - 64'd1));
	endfunction

	function automatic logic [ADDR_W-1:0] rand_address();
		return {$urandom, $urandom};
	endfunction

	task automatic send_address(input logic [ADDR_W-1:0] addr);
		int gap;
		req_ch.valid <= 1'b1;
		req_ch.address <= addr;
		offering = 1;
		do
			@(posedge clk);
		while (req_ch.ready !== 1'b1);
		pending_lookups.push_back(predict_access(addr));
		gap = quiet ? 0 : pick_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			offering = 0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		if (offering) begin
			req_ch.valid <= 1'b0;
			offering = 0;
		end
		while (pending_lookups.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_config(input logic [3:0] sb, input logic [3:0] ob,
			input logic [3:0] ways_data);
		wait_idle();
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_SET_BITS;
		cfg_data <= sb;
		@(posedge clk);
		cfg_index <= CFG_OFFSET_BITS;
		cfg_data <= ob;
		@(posedge clk);
		cfg_index <= CFG_WAYS_IN_USE;
		cfg_data <= ways_data;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_set_bits = sb;
		cur_offset_bits = ob;
		cur_ways = ways_data[WAYS_CFG_W-1:0];
	endtask

	// reset settings: fills, hits, eviction by lowest count and by lowest way on a tie
	task automatic test_reset_settings();
		int t;
		send_address(64'd0);
		send_address(64'h3f);
		send_address('1);
		send_address('1);
		for (t = 1; t <= 4; t++)
			send_address(make_address(64'(t), 1, 64'd0));
		send_address(make_address(64'd1, 1, 64'd5));
		send_address(make_address(64'd1, 1, 64'd6));
		send_address(make_address(64'd2, 1, 64'd7));
		send_address(make_address(64'd4, 1, 64'd8));
		send_address(make_address(64'd5, 1, 64'd0));
		send_address(make_address(64'd6, 1, 64'd0));
		for (t = 1; t <= 5; t++)
			send_address(make_address(64'(t), 2, 64'd0));
	endtask

	// field limits, oversized set bits, oversized offset, zero ways and too many ways
	task automatic test_setting_extremes();
		set_config(4'd0, 4'd0, 4'd1);
		send_address(64'd0);
		send_address(64'd1);
		send_address('1);
		set_config(4'd15, 4'd15, 4'd7);
		send_address('1);
		send_address(64'h7fff_ffff_ffff_ffff);
		send_address(64'h8000_0000_0000_0000);
		set_config(4'd8, 4'd12, 4'd0);
		send_address(make_address(64'd3, 200, 64'd1));
		send_address(make_address(64'd4, 200, 64'd2));
	endtask

	// lines above ways in use are skipped and kept intact
	task automatic test_way_limit();
		int t;
		set_config(4'd8, 4'd6, 4'd4);
		for (t = 1; t <= 4; t++)
			send_address(make_address(64'(t), 7, 64'd0));
		set_config(4'd8, 4'd6, 4'd2);
		send_address(make_address(64'd3, 7, 64'd0));
		send_address(make_address(64'd9, 7, 64'd0));
		set_config(4'd8, 4'd6, 4'd4);
		send_address(make_address(64'd4, 7, 64'd0));
	endtask

	// the busier line survives and the less used way is the victim
	task automatic test_lfu_victim();
		int i;
		set_config(4'd8, 4'd6, 4'd2);
		quiet = 1;
		send_address(make_address(64'h111, 'h5a, 64'd0));
		send_address(make_address(64'h222, 'h5a, 64'd0));
		for (i = 0; i < 24; i++)
			send_address(make_address(64'h111, 'h5a, 64'(i)));
		for (i = 0; i < 5; i++)
			send_address(make_address(64'h222, 'h5a, 64'(i)));
		send_address(make_address(64'h333, 'h5a, 64'd0));
		send_address(make_address(64'h111, 'h5a, 64'd0));
		quiet = 0;
		wait_idle();
	endtask

	// receiver holds off while addresses keep coming, then the sender waits for all
	task automatic test_backpressure();
		int i;
		set_config(4'd2, 4'd3, 4'd3);
		rsp_hold = 300;
		quiet = 1;
		for (i = 0; i < 40; i++)
			send_address(make_address(64'($urandom_range(0, 5)), $urandom_range(0, 3),
				rand_address()));
		quiet = 0;
		wait_idle();
	endtask

	task automatic test_random_streams();
		logic [ADDR_W-1:0] pool [16];
		int phase, i, r;
		logic [ADDR_W-1:0] addr, omask;
		for (phase = 0; phase < 8; phase++) begin
			case (phase)
				0: set_config(4'd8, 4'd6, 4'd4);
				1: set_config(4'd0, 4'd0, 4'd1);
				2: set_config(4'd15, 4'd15, 4'd7);
				3: set_config(4'd3, 4'd2, 4'd3);
				default: set_config(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
					4'($urandom_range(0, 15)));
			endcase
			for (i = 0; i < 16; i++)
				pool[i] = make_address(($urandom_range(0, 3) == 0) ? rand_address()
					: 64'($urandom_range(0, 9)), $urandom_range(0, 3), 64'd0);
			omask = (64'd1 << cur_offset_bits) - 64'd1;
			for (i = 0; i < PHASE_ITEMS; i++) begin
				r = $urandom_range(0, 99);
				if (r < 70)
					addr = (pool[$urandom_range(0, 15)] & ~omask) | (rand_address() & omask);
				else if (r < 85)
					addr = make_address(64'($urandom_range(0, 7)), $urandom_range(0, 3),
						rand_address());
				else
					addr = rand_address();
				send_address(addr);
			end
		end
	endtask

	// response side stalls
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else if (rsp_hold > 0) begin
			rsp_ch.ready <= 1'b0;
			rsp_hold--;
		end else if (quiet) begin
			rsp_ch.ready <= 1'b1;
		end else if (rsp_stall_left > 0) begin
			rsp_ch.ready <= 1'b0;
			rsp_stall_left--;
		end else begin
			rsp_ch.ready <= 1'b1;
			rsp_stall_left = pick_gap();
		end
	end

	// compare every response transfer with the oldest predicted lookup
	always @(posedge clk) begin
		lookup_result_t exp;
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			if (pending_lookups.size() == 0) begin
				$error("response transfer with no lookup outstanding");
				mismatches++;
			end else begin
				exp = pending_lookups.pop_front();
				if (rsp_ch.outcome !== exp.outcome) begin
					$error("outcome: expected %0d, got %0d", exp.outcome, rsp_ch.outcome);
					mismatches++;
				end
				if (rsp_ch.set_index !== exp.set_index) begin
					$error("set_index: expected %0d, got %0d", exp.set_index,
						rsp_ch.set_index);
					mismatches++;
				end
				if (rsp_ch.line_tag !== exp.line_tag) begin
					$error("line_tag: expected %h, got %h", exp.line_tag, rsp_ch.line_tag);
					mismatches++;
				end
				if (rsp_ch.way_used !== exp.way_used) begin
					$error("way_used: expected %0d, got %0d", exp.way_used, rsp_ch.way_used);
					mismatches++;
				end
				if (rsp_ch.hit_total !== exp.hit_total) begin
					$error("hit_total: expected %0d, got %0d", exp.hit_total,
						rsp_ch.hit_total);
					mismatches++;
				end
				if (rsp_ch.miss_total !== exp.miss_total) begin
					$error("miss_total: expected %0d, got %0d", exp.miss_total,
						rsp_ch.miss_total);
					mismatches++;
				end
				if (rsp_ch.evict_total !== exp.evict_total) begin
					$error("evict_total: expected %0d, got %0d", exp.evict_total,
						rsp_ch.evict_total);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1)
				|| (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("timeout: no transfer for %0d cycles", STALL_LIMIT);
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_SET_BITS;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.address = '0;
		cur_set_bits = SET_BITS_RST;
		cur_offset_bits = OFFSET_BITS_RST;
		cur_ways = WAYS_RST;
		mismatches = 0;
		rsp_hold = 0;
		idle_cycles = 0;
		quiet = 0;
		offering = 0;
		rsp_stall_left = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_settings();
		test_setting_extremes();
		test_way_limit();
		test_lfu_victim();
		test_backpressure();
		test_random_streams();
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
